[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the particle step core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/vps_pkg.sv]
// ----------------------------------------------------------------------------
// vps_pkg
// Types, constants and helpers shared by the particle step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vps_pkg;

    localparam int POS_W   = 22;
    localparam int PUSH_W  = 28;
    localparam int IM_W    = 16;
    localparam int DIR_W   = 16;
    localparam int RATIO_W = 16;
    localparam int SSQ_W   = 24;
    localparam int CFG_W   = 24;
    localparam int NN_W    = 46;
    localparam int RSQ_W   = 19;
    localparam int T_W     = 82;
    localparam int U_W     = 67;
    localparam int SH_W    = 5;

    localparam logic [POS_W-1:0]   POS_MAX      = 22'd4190208;
    localparam logic [16:0]        DIR_ONE      = 17'd16384;
    localparam logic [15:0]        INACTIVE_KEY = 16'hF000;
    localparam logic [RATIO_W-1:0] RATIO_RESET  = 16'd16384;
    localparam logic [SSQ_W-1:0]   SSQ_RESET    = 24'd4660;

    typedef enum logic [0:0] {
        CFG_STEP_RATIO   = 1'b0,
        CFG_STEP_SQUARED = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [RATIO_W-1:0] step_ratio;
        logic [SSQ_W-1:0]   step_squared;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0]         cur_x;
        logic [POS_W-1:0]         cur_y;
        logic [POS_W-1:0]         prev_x;
        logic [POS_W-1:0]         prev_y;
        logic signed [PUSH_W-1:0] push_x;
        logic signed [PUSH_W-1:0] push_y;
        logic [IM_W-1:0]          inv_mass;
        logic                     inactive;
    } in_t;

    typedef struct packed {
        logic                    inactive;
        logic [POS_W-1:0]        next_x;
        logic [POS_W-1:0]        next_y;
        logic signed [POS_W:0]   dx;
        logic signed [POS_W:0]   dy;
        logic [NN_W-1:0]         nn;
        logic [SH_W-1:0]         s;
        logic [T_W-1:0]          t;
        logic signed [U_W-1:0]   u;
        logic [RSQ_W-1:0]        r;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]        next_x;
        logic [POS_W-1:0]        next_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [8:0]              cell_code_x;
        logic [8:0]              cell_code_y;
        logic [10:0]             near_code_x;
        logic [10:0]             near_code_y;
        logic [15:0]             morton_key;
    } res_t;

    // Spreads six bits to the even positions of an 11-bit word.
    function automatic logic [10:0] spread6(input logic [5:0] v);
        logic [10:0] o;
        o = '0;
        for (int i = 0; i < 6; i++) begin
            o[2*i] = v[i];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[hdl/vps_front.sv]
// ----------------------------------------------------------------------------
// vps_front
// Three-stage position update and squared motion norm.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_front import vps_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire in_t   in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_data
);

    typedef struct packed {
        logic                 inactive;
        logic [POS_W-1:0]     cur_x;
        logic [POS_W-1:0]     cur_y;
        logic signed [22:0]   dx;
        logic signed [22:0]   dy;
        logic signed [44:0]   pm_x;
        logic signed [44:0]   pm_y;
        logic signed [38:0]   dsr_x;
        logic signed [38:0]   dsr_y;
        logic [43:0]          dx2;
        logic [43:0]          dy2;
    } f1_t;

    typedef struct packed {
        logic                 inactive;
        logic [POS_W-1:0]     cur_x;
        logic [POS_W-1:0]     cur_y;
        logic signed [22:0]   dx;
        logic signed [22:0]   dy;
        logic signed [38:0]   dsr_x;
        logic signed [38:0]   dsr_y;
        logic signed [57:0]   as_x;
        logic signed [57:0]   as_y;
        logic [44:0]          n2;
    } f2_t;

    logic [2:0] vld_reg;
    logic [3:0] rdy;
    f1_t   f1_reg, f1_next;
    f2_t   f2_reg, f2_next;
    item_t f3_reg, f3_next;

    assign rdy[3]   = out_ready;
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    // Stage one: differences and the raw products.
    always_comb begin
        logic signed [44:0] push_xe, push_ye, im_e, dxe, dye, sqx, sqy;
        logic signed [38:0] dx39, dy39, ratio_e;
        f1_next.inactive = in_data.inactive;
        f1_next.cur_x    = in_data.cur_x;
        f1_next.cur_y    = in_data.cur_y;
        f1_next.dx = $signed({1'b0, in_data.cur_x}) - $signed({1'b0, in_data.prev_x});
        f1_next.dy = $signed({1'b0, in_data.cur_y}) - $signed({1'b0, in_data.prev_y});
        push_xe = 45'(in_data.push_x);
        push_ye = 45'(in_data.push_y);
        im_e    = $signed({29'b0, in_data.inv_mass});
        f1_next.pm_x = push_xe * im_e;
        f1_next.pm_y = push_ye * im_e;
        dx39    = 39'(f1_next.dx);
        dy39    = 39'(f1_next.dy);
        ratio_e = $signed({23'b0, cfg.step_ratio});
        f1_next.dsr_x = dx39 * ratio_e;
        f1_next.dsr_y = dy39 * ratio_e;
        dxe = 45'(f1_next.dx);
        dye = 45'(f1_next.dy);
        sqx = dxe * dxe;
        sqy = dye * dye;
        f1_next.dx2 = sqx[43:0];
        f1_next.dy2 = sqy[43:0];
    end

    // Stage two: rounded acceleration times step squared, norm sum.
    always_comb begin
        logic signed [44:0] rx, ry;
        logic signed [57:0] ax, ay, ss_e;
        f2_next.inactive = f1_reg.inactive;
        f2_next.cur_x    = f1_reg.cur_x;
        f2_next.cur_y    = f1_reg.cur_y;
        f2_next.dx       = f1_reg.dx;
        f2_next.dy       = f1_reg.dy;
        f2_next.dsr_x    = f1_reg.dsr_x;
        f2_next.dsr_y    = f1_reg.dsr_y;
        rx   = (f1_reg.pm_x + 45'sd2048) >>> 12;
        ry   = (f1_reg.pm_y + 45'sd2048) >>> 12;
        ax   = 58'(rx);
        ay   = 58'(ry);
        ss_e = $signed({34'b0, cfg.step_squared});
        f2_next.as_x = ax * ss_e;
        f2_next.as_y = ay * ss_e;
        f2_next.n2   = {1'b0, f1_reg.dx2} + {1'b0, f1_reg.dy2};
    end

    function automatic logic [POS_W-1:0] settle(input logic [POS_W-1:0] cur,
                                                input logic signed [38:0] dsr,
                                                input logic signed [57:0] acs);
        logic signed [59:0] sum, q, dsr_e, acs_e;
        dsr_e = 60'(dsr);
        acs_e = 60'(acs);
        sum = $signed({14'b0, cur, 24'b0}) + (dsr_e <<< 10) + acs_e;
        q   = (sum + 60'sd8388608) >>> 24;
        if (q < 0) begin
            return '0;
        end else if (q > $signed({38'b0, POS_MAX})) begin
            return POS_MAX;
        end
        return q[POS_W-1:0];
    endfunction

    // Stage three: exact sum, rounding and clamp.
    always_comb begin
        f3_next          = '0;
        f3_next.inactive = f2_reg.inactive;
        f3_next.next_x   = settle(f2_reg.cur_x, f2_reg.dsr_x, f2_reg.as_x);
        f3_next.next_y   = settle(f2_reg.cur_y, f2_reg.dsr_y, f2_reg.as_y);
        f3_next.dx       = f2_reg.dx;
        f3_next.dy       = f2_reg.dy;
        f3_next.nn       = {1'b0, f2_reg.n2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid)   f1_reg <= f1_next;
        if (rdy[1] && vld_reg[0]) f2_reg <= f2_next;
        if (rdy[2] && vld_reg[1]) f3_reg <= f3_next;
    end

    assign out_valid = vld_reg[2];
    assign out_data  = f3_reg;

endmodule

`default_nettype wire

[hdl/vps_norm.sv]
// ----------------------------------------------------------------------------
// vps_norm
// Five-stage even normalization of the squared norm into [2^44, 2^46).
// ----------------------------------------------------------------------------
`default_nettype none

module vps_norm import vps_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_data
);

    localparam int N = 5;

    logic [N-1:0] vld_reg;
    logic [N:0]   rdy;
    item_t        dat_reg [N];

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[N-1];
    assign out_data  = dat_reg[N-1];

    for (genvar j = 0; j < N; j++) begin : g_stage
        // Shift by 32, 16, 8, 4 and 2 bits in turn when the value stays in range.
        localparam int SH = 2 << (N - 1 - j);
        item_t src, dat_next;
        logic  vin;

        if (j == 0) begin : g_first
            assign src = in_data;
            assign vin = in_valid;
        end else begin : g_rest
            assign src = dat_reg[j-1];
            assign vin = vld_reg[j-1];
        end

        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        always_comb begin
            dat_next = src;
            if ((src.nn >> (NN_W - SH)) == '0) begin
                dat_next.nn = src.nn << SH;
                dat_next.s  = src.s + SH_W'(SH / 2);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j] && vin) dat_reg[j] <= dat_next;
        end
    end

endmodule

`default_nettype wire

[hdl/vps_rsqrt.sv]
// ----------------------------------------------------------------------------
// vps_rsqrt
// Bit-per-stage search for the correctly rounded 2^40 / sqrt(nn).
// ----------------------------------------------------------------------------
`default_nettype none

module vps_rsqrt import vps_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_data
);

    localparam int N = RSQ_W;

    logic [N-1:0] vld_reg;
    logic [N:0]   rdy;
    item_t        dat_reg [N];

    assign rdy[N]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[N-1];
    assign out_data  = dat_reg[N-1];

    // Each stage decides one bit of m, keeping t = (2m-1)^2 * nn and
    // u = (2m-1) * nn up to date with shifts and adds. A bit is kept while
    // t stays below 2^82, which is the rounding condition for the result.
    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int K = N - 1 - j;
        item_t src, dat_next;
        logic  vin;
        logic signed [88:0] cand, u_e;
        logic signed [U_W-1:0] u_add;

        if (j == 0) begin : g_first
            always_comb begin
                src   = in_data;
                src.t = T_W'(in_data.nn);
                src.u = -$signed({{(U_W-NN_W){1'b0}}, in_data.nn});
                src.r = '0;
            end
            assign vin = in_valid;
        end else begin : g_rest
            assign src = dat_reg[j-1];
            assign vin = vld_reg[j-1];
        end

        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        always_comb begin
            u_e   = src.u;
            cand  = $signed({7'b0, src.t}) + (u_e <<< (K + 2))
                  + $signed({43'b0, src.nn} << (2 * K + 2));
            u_add = $signed({{(U_W-NN_W){1'b0}}, src.nn} << (K + 1));
            dat_next = src;
            if (cand[88:T_W] == '0) begin
                dat_next.t    = cand[T_W-1:0];
                dat_next.u    = src.u + u_add;
                dat_next.r[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                vld_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[j] && vin) dat_reg[j] <= dat_next;
        end
    end

endmodule

`default_nettype wire

[hdl/vps_dir.sv]
// ----------------------------------------------------------------------------
// vps_dir
// Two-stage direction scaling, cell codes and Morton key.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_dir import vps_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_data
);

    typedef struct packed {
        logic             inactive;
        logic [POS_W-1:0] next_x;
        logic [POS_W-1:0] next_y;
        logic             neg_x;
        logic             neg_y;
        logic [41:0]      prod_x;
        logic [41:0]      prod_y;
    } d1_t;

    logic [1:0] vld_reg;
    logic [2:0] rdy;
    d1_t  d1_reg, d1_next;
    res_t d2_reg, d2_next;

    assign rdy[2]   = out_ready;
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    function automatic logic [41:0] scale(input logic signed [22:0] d,
                                          input logic [SH_W-1:0] s,
                                          input logic [RSQ_W-1:0] r);
        logic [22:0] a;
        logic [53:0] sh;
        a  = (d < 0) ? 23'(-d) : 23'(d);
        sh = {31'b0, a} << s;
        return 42'(sh[22:0]) * 42'(r);
    endfunction

    function automatic logic [DIR_W-1:0] finish(input logic [41:0] p, input logic neg);
        logic [16:0] q, nq;
        q = 17'((p + 42'd33554432) >> 26);
        if (q > DIR_ONE) q = DIR_ONE;
        nq = 17'd0 - q;
        return neg ? nq[DIR_W-1:0] : q[DIR_W-1:0];
    endfunction

    always_comb begin
        d1_next.inactive = in_data.inactive;
        d1_next.next_x   = in_data.next_x;
        d1_next.next_y   = in_data.next_y;
        d1_next.neg_x    = in_data.dx < 0;
        d1_next.neg_y    = in_data.dy < 0;
        d1_next.prod_x   = scale(in_data.dx, in_data.s, in_data.r);
        d1_next.prod_y   = scale(in_data.dy, in_data.s, in_data.r);
    end

    always_comb begin
        logic [9:0]  ix, iy;
        logic [5:0]  nbx, nby;
        logic [10:0] cx, cy;
        ix  = d1_reg.next_x[POS_W-1:12];
        iy  = d1_reg.next_y[POS_W-1:12];
        nbx = {1'b0, ix[9:5]} + (ix[4] ? 6'd1 : 6'd63);
        nby = {1'b0, iy[9:5]} + (iy[4] ? 6'd1 : 6'd63);
        cx  = spread6({1'b0, ix[9:5]});
        cy  = spread6({1'b0, iy[9:5]});
        d2_next.next_x      = d1_reg.next_x;
        d2_next.next_y      = d1_reg.next_y;
        d2_next.dir_x       = finish(d1_reg.prod_x, d1_reg.neg_x);
        d2_next.dir_y       = finish(d1_reg.prod_y, d1_reg.neg_y);
        d2_next.cell_code_x = cx[8:0];
        d2_next.cell_code_y = cy[8:0];
        d2_next.near_code_x = spread6(nbx);
        d2_next.near_code_y = spread6(nby);
        d2_next.morton_key  = {6'b0, cx[8:0], 1'b0} + {7'b0, cy[8:0]}
                            + (d1_reg.inactive ? INACTIVE_KEY : 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid)   d1_reg <= d1_next;
        if (rdy[1] && vld_reg[0]) d2_reg <= d2_next;
    end

    assign out_valid = vld_reg[1];
    assign out_data  = d2_reg;

endmodule

`default_nettype wire

[hdl/verlet_particle_step_morton_core.sv]
// ----------------------------------------------------------------------------
// verlet_particle_step_morton_core
// Verlet position step of one 2-D particle with unit direction and Morton
// cell key, as a fully pipelined stream core.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                      | Moves
//   --------+----------------------------+------------------------------------
//   input   | s_valid / s_ready / s_*    | one particle item
//   result  | m_valid / m_ready / m_*    | one result item per particle
//   config  | cfg_wr_en / cfg_index / .. | step_ratio, step_squared writes
//
// The core takes one item per cycle unless m_ready holds it back. Each item
// passes three stages of position arithmetic, five normalization stages,
// nineteen stages of the reciprocal square root search (one bit each) and
// two stages of direction scaling and cell coding. The reciprocal search
// sets the depth. Reset (aresetn low at a clock edge) empties the pipeline
// and loads the register defaults. Each stage holds its item only while the
// one after it is full and stalled, so bubbles close up and an item is taken
// whenever the first stage can move, even while a result waits on m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module verlet_particle_step_morton_core import vps_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration writes.
    input  wire logic                      cfg_wr_en,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    // Particle items.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [POS_W-1:0]          s_cur_x,
    input  wire logic [POS_W-1:0]          s_cur_y,
    input  wire logic [POS_W-1:0]          s_prev_x,
    input  wire logic [POS_W-1:0]          s_prev_y,
    input  wire logic signed [PUSH_W-1:0]  s_push_x,
    input  wire logic signed [PUSH_W-1:0]  s_push_y,
    input  wire logic [IM_W-1:0]           s_inv_mass,
    input  wire logic                      s_inactive,
    // Result items.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [POS_W-1:0]               m_next_x,
    output logic [POS_W-1:0]               m_next_y,
    output logic signed [DIR_W-1:0]        m_dir_x,
    output logic signed [DIR_W-1:0]        m_dir_y,
    output logic [8:0]                     m_cell_code_x,
    output logic [8:0]                     m_cell_code_y,
    output logic [10:0]                    m_near_code_x,
    output logic [10:0]                    m_near_code_y,
    output logic [15:0]                    m_morton_key
);

    // Config registers; user changes only while pipeline is empty; unchecked.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_ratio   <= RATIO_RESET;
            cfg_reg.step_squared <= SSQ_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_STEP_RATIO:   cfg_reg.step_ratio   <= cfg_data[RATIO_W-1:0];
                CFG_STEP_SQUARED: cfg_reg.step_squared <= cfg_data[SSQ_W-1:0];
                default: ;
            endcase
        end
    end

    in_t   in_item;
    item_t fr_data, nm_data, rs_data;
    res_t  res;
    logic  fr_valid, fr_ready, nm_valid, nm_ready, rs_valid, rs_ready;

    assign in_item.cur_x    = s_cur_x;
    assign in_item.cur_y    = s_cur_y;
    assign in_item.prev_x   = s_prev_x;
    assign in_item.prev_y   = s_prev_y;
    assign in_item.push_x   = s_push_x;
    assign in_item.push_y   = s_push_y;
    assign in_item.inv_mass = s_inv_mass;
    assign in_item.inactive = s_inactive;

    // Position update and squared norm of the motion.
    vps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_item),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    // Even shift of the norm into the window the search expects.
    vps_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (nm_valid),
        .out_ready (nm_ready),
        .out_data  (nm_data)
    );

    // Correctly rounded reciprocal square root, one result bit per stage.
    vps_rsqrt u_rsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (nm_valid),
        .in_ready  (nm_ready),
        .in_data   (nm_data),
        .out_valid (rs_valid),
        .out_ready (rs_ready),
        .out_data  (rs_data)
    );

    // Direction components, cell codes and key; its last stage is the
    // output register.
    vps_dir u_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rs_valid),
        .in_ready  (rs_ready),
        .in_data   (rs_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res)
    );

    assign m_next_x      = res.next_x;
    assign m_next_y      = res.next_y;
    assign m_dir_x       = res.dir_x;
    assign m_dir_y       = res.dir_y;
    assign m_cell_code_x = res.cell_code_x;
    assign m_cell_code_y = res.cell_code_y;
    assign m_near_code_x = res.near_code_x;
    assign m_near_code_y = res.near_code_y;
    assign m_morton_key  = res.morton_key;

    // The input side only stalls when every stage is full and the result
    // is held back.
    `ASSERT_ON(a_stall_source, aclk, aresetn, !s_ready |-> (m_valid && !m_ready), "input stalled without a blocked result")
    // The pipeline is empty right after reset.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    // Direction components never exceed one in magnitude.
    `ASSERT_ON(a_dir_range, aclk, aresetn, m_valid |-> (m_dir_x <= 16'sd16384 && m_dir_x >= -16'sd16384 && m_dir_y <= 16'sd16384 && m_dir_y >= -16'sd16384), "direction out of range")

endmodule

`default_nettype wire
